// ===== hdl/rscp_pkg.sv =====
// ----------------------------------------------------------------------------
// rscp_pkg
// Shared types, fourcc constants and helpers of the RIFF subtitle chunk parser.
// ----------------------------------------------------------------------------
package rscp_pkg;

  // fourcc codes as they appear little-endian in a 32-bit word
  localparam logic [31:0] RIFF_ID = 32'h4646_4952;
  localparam logic [31:0] LIST_ID = 32'h5453_494C;
  localparam logic [31:0] STRH_ID = 32'h6872_7473;
  localparam logic [31:0] TXTS_ID = 32'h7374_7874;
  localparam logic [31:0] GAB2_ID = 32'h3242_4147;

  localparam logic [7:0] NO_STREAM = 8'd255;
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;

  // GAB2 record types
  localparam logic [15:0] REC_LANG      = 16'd0;
  localparam logic [15:0] REC_ENTRY     = 16'd1;
  localparam logic [15:0] REC_LANG_UNI  = 16'd2;
  localparam logic [15:0] REC_ENTRY_UNI = 16'd3;
  localparam logic [15:0] REC_TEXT      = 16'd4;

  // result item kinds
  typedef enum logic [2:0] {
    KIND_TEXT     = 3'd0,
    KIND_LANG     = 3'd1,
    KIND_ENTRY    = 3'd2,
    KIND_STREAM   = 3'd3,
    KIND_BAD_CHNK = 3'd4,
    KIND_BAD_REC  = 3'd5
  } kind_t;

  typedef enum logic [12:0] {
    PH_HDR_ID    = 13'b0_0000_0000_0001,
    PH_LIST_LEN  = 13'b0_0000_0000_0010,
    PH_LIST_TYPE = 13'b0_0000_0000_0100,
    PH_STRH_LEN  = 13'b0_0000_0000_1000,
    PH_STRH_TYPE = 13'b0_0000_0001_0000,
    PH_SUB_LEN   = 13'b0_0000_0010_0000,
    PH_SUB_ID    = 13'b0_0000_0100_0000,
    PH_GAB_PAD   = 13'b0_0000_1000_0000,
    PH_REC_TYPE  = 13'b0_0001_0000_0000,
    PH_REC_LEN   = 13'b0_0010_0000_0000,
    PH_REC_DATA  = 13'b0_0100_0000_0000,
    PH_SKIP      = 13'b0_1000_0000_0000,
    PH_OTHER_LEN = 13'b1_0000_0000_0000
  } phase_t;

  function automatic logic [31:0] sub_clamp(input logic [31:0] a, input logic [31:0] b);
    sub_clamp = (a > b) ? (a - b) : 32'd0;
  endfunction

endpackage

// ===== hdl/rscp_if.sv =====
// ----------------------------------------------------------------------------
// rscp channel interfaces
// Valid/ready channels for file bytes in and parsed result items out.
// ----------------------------------------------------------------------------
interface rscp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;

  modport source (output valid, output data_byte, output file_start, input ready);
  modport sink   (input valid, input data_byte, input file_start, output ready);
endinterface

interface rscp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] value;
  logic [7:0]  stream_number;
  logic        last_of_record;

  modport source (output valid, output kind, output value, output stream_number,
                  output last_of_record, input ready);
  modport sink   (input valid, input kind, input value, input stream_number,
                  input last_of_record, output ready);
endinterface

// ===== hdl/riff_subtitle_chunk_parser.sv =====
// ----------------------------------------------------------------------------
// riff_subtitle_chunk_parser
// Walks the RIFF chunks of an AVI byte stream, reports stream types and
// extracts GAB2 subtitle records of the last text stream byte by byte.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                       handshake
//  in_chan   in   data_byte[7:0], file_start                    valid/ready
//  out_chan  out  kind[2:0], value[31:0], stream_number[7:0],   valid/ready
//                 last_of_record
//
//  one byte per cycle; a byte's result item is in the output register the
//  cycle after it is taken, set by the single parse step per accepted byte
//  reset is synchronous on rst_n; in_chan.ready is low while it is asserted
//  in_chan.ready stays high while the output register is empty or being read,
//  so a stalled result item holds off further bytes until it is taken
// ----------------------------------------------------------------------------
module riff_subtitle_chunk_parser (
  input  logic       clk,
  input  logic       rst_n,
  rscp_in_if.sink    in_chan,
  rscp_out_if.source out_chan
);
  import rscp_pkg::*;

  phase_t      phase_r, phase_nxt, cur_phase;
  logic [31:0] field_r, field_nxt, cur_field;
  logic [2:0]  cnt_r, cnt_nxt, cur_cnt;
  logic [31:0] chunk_rem_r, chunk_rem_nxt, cur_chunk_rem;
  logic [31:0] rec_rem_r, rec_rem_nxt, cur_rec_rem;
  logic [15:0] rec_type_r, rec_type_nxt, cur_rec_type;
  logic [7:0]  stream_cnt_r, stream_cnt_nxt, cur_stream_cnt;
  logic [7:0]  sub_stream_r, sub_stream_nxt, cur_sub_stream;
  logic        toggle_r, toggle_nxt, cur_toggle;
  logic        zero_seen_r, zero_seen_nxt, cur_zero_seen;
  logic        pad_r, pad_nxt, cur_pad;

  logic        out_valid_r;
  kind_t       out_kind_r;
  logic [31:0] out_value_r;
  logic [7:0]  out_num_r;
  logic        out_last_r;

  logic        accept;
  logic        emit;
  kind_t       e_kind;
  logic [31:0] e_value;
  logic [7:0]  e_num;
  logic        e_last;

  logic [7:0]  b;
  logic [2:0]  cnt_inc;
  logic [31:0] coll;
  logic        done4, done2;
  logic [3:0]  dig1, dig2;
  logic [6:0]  id_num;
  logic        id_digits;
  logic        is_sub;
  logic [31:0] cr4, cr1, cm6, cr_left;
  logic [31:0] rr_dec;
  logic        uni, kept;
  kind_t       txt_kind;

  function automatic phase_t skip_phase(input logic [31:0] cr);
    skip_phase = (cr == 32'd0) ? PH_HDR_ID : PH_SKIP;
  endfunction

  function automatic phase_t gab_phase(input logic [31:0] cr);
    gab_phase = (cr >= 32'd6) ? PH_REC_TYPE : skip_phase(cr);
  endfunction

  assign in_chan.ready = rst_n && (!out_valid_r || out_chan.ready);
  assign accept        = in_chan.valid && in_chan.ready;

  // a file start restarts parsing from reset values before the byte is used
  always_comb begin
    if (in_chan.file_start) begin
      cur_phase      = PH_HDR_ID;
      cur_field      = '0;
      cur_cnt        = '0;
      cur_chunk_rem  = '0;
      cur_rec_rem    = '0;
      cur_rec_type   = '0;
      cur_stream_cnt = '0;
      cur_sub_stream = NO_STREAM;
      cur_toggle     = 1'b0;
      cur_zero_seen  = 1'b0;
      cur_pad        = 1'b0;
    end else begin
      cur_phase      = phase_r;
      cur_field      = field_r;
      cur_cnt        = cnt_r;
      cur_chunk_rem  = chunk_rem_r;
      cur_rec_rem    = rec_rem_r;
      cur_rec_type   = rec_type_r;
      cur_stream_cnt = stream_cnt_r;
      cur_sub_stream = sub_stream_r;
      cur_toggle     = toggle_r;
      cur_zero_seen  = zero_seen_r;
      cur_pad        = pad_r;
    end
  end

  // per-byte helpers, all from registered state and the incoming byte
  always_comb begin
    b       = in_chan.data_byte;
    cnt_inc = cur_cnt + 3'd1;
    coll    = cur_field | (32'(b) << {cur_cnt[1:0], 3'b000});
    done4   = cnt_inc >= 3'd4;
    done2   = cnt_inc >= 3'd2;

    dig1      = 4'(coll[7:0] - ASCII_ZERO);
    dig2      = 4'(coll[15:8] - ASCII_ZERO);
    id_digits = (coll[7:0] >= ASCII_ZERO) && (coll[7:0] <= ASCII_NINE) &&
                (coll[15:8] >= ASCII_ZERO) && (coll[15:8] <= ASCII_NINE);
    id_num    = 7'(dig1) * 7'd10 + 7'(dig2);
    is_sub    = id_digits && (cur_sub_stream != NO_STREAM) &&
                ({1'b0, id_num} == cur_sub_stream);

    cr4     = sub_clamp(cur_chunk_rem, 32'd4);
    cr1     = sub_clamp(cur_chunk_rem, 32'd1);
    cm6     = sub_clamp(cur_chunk_rem, 32'd6);
    cr_left = cm6 - coll;
    rr_dec  = cur_rec_rem - 32'd1;

    uni  = (cur_rec_type == REC_LANG_UNI) || (cur_rec_type == REC_ENTRY_UNI);
    kept = !uni || !cur_toggle;
    if ((cur_rec_type == REC_LANG) || (cur_rec_type == REC_LANG_UNI)) begin
      txt_kind = KIND_LANG;
    end else if ((cur_rec_type == REC_ENTRY) || (cur_rec_type == REC_ENTRY_UNI)) begin
      txt_kind = KIND_ENTRY;
    end else begin
      txt_kind = KIND_TEXT;
    end
  end

  always_comb begin
    phase_nxt      = cur_phase;
    field_nxt      = cur_field;
    cnt_nxt        = cur_cnt;
    chunk_rem_nxt  = cur_chunk_rem;
    rec_rem_nxt    = cur_rec_rem;
    rec_type_nxt   = cur_rec_type;
    stream_cnt_nxt = cur_stream_cnt;
    sub_stream_nxt = cur_sub_stream;
    toggle_nxt     = cur_toggle;
    zero_seen_nxt  = cur_zero_seen;
    pad_nxt        = cur_pad;
    emit           = 1'b0;
    e_kind         = KIND_TEXT;
    e_value        = 32'd0;
    e_num          = cur_sub_stream;
    e_last         = 1'b1;

    case (cur_phase)
      PH_HDR_ID: begin
        field_nxt = coll;
        cnt_nxt   = cnt_inc;
        if (done4) begin
          if ((coll == RIFF_ID) || (coll == LIST_ID)) begin
            phase_nxt = PH_LIST_LEN;
          end else if (coll == STRH_ID) begin
            phase_nxt = PH_STRH_LEN;
          end else if (is_sub) begin
            phase_nxt = PH_SUB_LEN;
          end else begin
            phase_nxt = PH_OTHER_LEN;
          end
        end
      end
      PH_LIST_LEN: begin
        field_nxt = coll;
        cnt_nxt   = cnt_inc;
        if (done4) begin
          phase_nxt = PH_LIST_TYPE;
        end
      end
      PH_LIST_TYPE: begin
        field_nxt = coll;
        cnt_nxt   = cnt_inc;
        if (done4) begin
          phase_nxt = PH_HDR_ID;
        end
      end
      PH_STRH_LEN, PH_SUB_LEN: begin
        field_nxt = coll;
        cnt_nxt   = cnt_inc;
        if (done4) begin
          chunk_rem_nxt = coll;
          phase_nxt     = (cur_phase == PH_STRH_LEN) ? PH_STRH_TYPE : PH_SUB_ID;
        end
      end
      PH_OTHER_LEN: begin
        field_nxt = coll;
        cnt_nxt   = cnt_inc;
        if (done4) begin
          chunk_rem_nxt = coll;
          pad_nxt       = coll[0];
          phase_nxt     = skip_phase(coll);
        end
      end
      PH_STRH_TYPE: begin
        field_nxt = coll;
        cnt_nxt   = cnt_inc;
        if (done4) begin
          emit    = 1'b1;
          e_kind  = KIND_STREAM;
          e_value = coll;
          e_num   = cur_stream_cnt;
          if (coll == TXTS_ID) begin
            sub_stream_nxt = cur_stream_cnt;
          end
          if (cur_stream_cnt != 8'd255) begin
            stream_cnt_nxt = cur_stream_cnt + 8'd1;
          end
          chunk_rem_nxt = cr4;
          pad_nxt       = cr4[0];
          phase_nxt     = skip_phase(cr4);
        end
      end
      PH_SUB_ID: begin
        field_nxt = coll;
        cnt_nxt   = cnt_inc;
        if (done4) begin
          chunk_rem_nxt = cr4;
          if (coll != GAB2_ID) begin
            emit      = 1'b1;
            e_kind    = KIND_BAD_CHNK;
            e_value   = coll;
            pad_nxt   = cr4[0];
            phase_nxt = skip_phase(cr4);
          end else begin
            phase_nxt = PH_GAB_PAD;
          end
        end
      end
      PH_GAB_PAD: begin
        chunk_rem_nxt = cr1;
        phase_nxt     = gab_phase(cr1);
        if (cr1 < 32'd6) begin
          pad_nxt = cr1[0];
        end
      end
      PH_REC_TYPE: begin
        field_nxt = coll;
        cnt_nxt   = cnt_inc;
        if (done2) begin
          rec_type_nxt = coll[15:0];
          phase_nxt    = PH_REC_LEN;
        end
      end
      PH_REC_LEN: begin
        field_nxt = coll;
        cnt_nxt   = cnt_inc;
        if (done4) begin
          rec_rem_nxt = coll;
          if (coll > cm6) begin
            // record overruns the chunk: give up on the rest of it
            chunk_rem_nxt = cm6;
            pad_nxt       = cm6[0];
            phase_nxt     = skip_phase(cm6);
          end else begin
            chunk_rem_nxt = cr_left;
            if (cur_rec_type > REC_TEXT) begin
              emit    = 1'b1;
              e_kind  = KIND_BAD_REC;
              e_value = 32'(cur_rec_type);
            end
            toggle_nxt    = 1'b0;
            zero_seen_nxt = 1'b0;
            if (coll == 32'd0) begin
              phase_nxt = gab_phase(cr_left);
              if (cr_left < 32'd6) begin
                pad_nxt = cr_left[0];
              end
            end else begin
              phase_nxt = PH_REC_DATA;
            end
          end
        end
      end
      PH_REC_DATA: begin
        rec_rem_nxt = rr_dec;
        toggle_nxt  = !cur_toggle;
        if (kept && (cur_rec_type <= REC_TEXT) && !cur_zero_seen) begin
          emit    = 1'b1;
          e_kind  = txt_kind;
          e_value = 32'(b);
          if (b == 8'd0) begin
            zero_seen_nxt = 1'b1;
          end else begin
            e_last = uni ? (rr_dec <= 32'd1) : (rr_dec == 32'd0);
          end
        end
        if (rr_dec == 32'd0) begin
          phase_nxt = gab_phase(cur_chunk_rem);
          if (cur_chunk_rem < 32'd6) begin
            pad_nxt = cur_chunk_rem[0];
          end
        end
      end
      PH_SKIP: begin
        if (cur_chunk_rem != 32'd0) begin
          chunk_rem_nxt = cur_chunk_rem - 32'd1;
        end else begin
          pad_nxt = 1'b0;
        end
        if ((chunk_rem_nxt == 32'd0) && !pad_nxt) begin
          phase_nxt = PH_HDR_ID;
        end
      end
      default: begin
        phase_nxt = PH_HDR_ID;
      end
    endcase

    // every phase change starts a fresh field
    if (phase_nxt != cur_phase) begin
      field_nxt = '0;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HDR_ID;
      field_r      <= '0;
      cnt_r        <= '0;
      chunk_rem_r  <= '0;
      rec_rem_r    <= '0;
      rec_type_r   <= '0;
      stream_cnt_r <= '0;
      sub_stream_r <= NO_STREAM;
      toggle_r     <= 1'b0;
      zero_seen_r  <= 1'b0;
      pad_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        phase_r      <= phase_nxt;
        field_r      <= field_nxt;
        cnt_r        <= cnt_nxt;
        chunk_rem_r  <= chunk_rem_nxt;
        rec_rem_r    <= rec_rem_nxt;
        rec_type_r   <= rec_type_nxt;
        stream_cnt_r <= stream_cnt_nxt;
        sub_stream_r <= sub_stream_nxt;
        toggle_r     <= toggle_nxt;
        zero_seen_r  <= zero_seen_nxt;
        pad_r        <= pad_nxt;
      end
      if (accept && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_kind_r  <= e_kind;
      out_value_r <= e_value;
      out_num_r   <= e_num;
      out_last_r  <= e_last;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.kind           = out_kind_r;
  assign out_chan.value          = out_value_r;
  assign out_chan.stream_number  = out_num_r;
  assign out_chan.last_of_record = out_last_r;

endmodule

// ===== hdl/rscp_chk.sv =====
// ----------------------------------------------------------------------------
// rscp_chk
// Port-level checks of the RIFF subtitle chunk parser, bound to the top level.
// ----------------------------------------------------------------------------
module rscp_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [31:0] out_value,
  input logic [7:0]  out_stream_number,
  input logic        out_last_of_record
);
  import rscp_pkg::*;

  // a stalled result item holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_value) &&
      $stable(out_stream_number) && $stable(out_last_of_record))
    else $error("stalled result item changed");

  // a new result item only appears after a byte was taken
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid) |-> $past(in_valid && in_ready))
    else $error("result item without an input byte");

  // an empty output register never blocks the input
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // single reports always close their record
  a_report_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_STREAM || out_kind == KIND_BAD_CHNK ||
      out_kind == KIND_BAD_REC) |-> out_last_of_record)
    else $error("report item without last_of_record");

  // text items carry a single byte
  a_text_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_TEXT || out_kind == KIND_LANG ||
      out_kind == KIND_ENTRY) |-> out_value[31:8] == 24'd0)
    else $error("text item wider than a byte");

endmodule

bind riff_subtitle_chunk_parser rscp_chk u_rscp_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_chan.valid),
  .in_ready          (in_chan.ready),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .out_kind          (out_chan.kind),
  .out_value         (out_chan.value),
  .out_stream_number (out_chan.stream_number),
  .out_last_of_record(out_chan.last_of_record)
);
